// ===== sv/mpd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpd_pkg: shared constants, types and helpers of the masked pose distance
// Fixed-point constants for pi, result and sum widths, stage counts and
// configuration register indexes.
// ----------------------------------------------------------------------------
package mpd_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int NUM_AXES   = 6;
    localparam int NUM_LINEAR = 3;

    localparam int DIST_WIDTH = 26;
    localparam int SQ_WIDTH   = 2 * DIST_WIDTH;
    localparam int SUM_WIDTH  = SQ_WIDTH + 3;

    localparam logic [DIST_WIDTH-1:0] DIST_MAX = '1;

    localparam int LANE_STAGES  = 6;
    localparam int MERGE_STAGES = 2;
    localparam int SQRT_STAGES  = DIST_WIDTH;
    localparam int NUM_STAGES   = LANE_STAGES + MERGE_STAGES + SQRT_STAGES;

    localparam int CFG_IDX_WIDTH = 3;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_TARGET_X     = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_TARGET_Y     = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_TARGET_Z     = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_TARGET_ALPHA = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_TARGET_BETA  = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_TARGET_GAMMA = 3'd5;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_AXIS_MASK    = 3'd6;

    localparam logic [NUM_AXES-1:0] AXIS_MASK_RESET = '1;

    // pi with 60 fractional bits
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

    typedef logic [DIST_WIDTH-1:0] t_dist;
    typedef logic [SQ_WIDTH-1:0]   t_sq;
    typedef logic [SUM_WIDTH-1:0]  t_sum;

    // pi rounded to nearest at the given number of fractional bits
    function automatic logic [63:0] pi_fx(input int frac);
        return (PI_Q60 + (64'd1 << (59 - frac))) >> (60 - frac);
    endfunction

    // two pi rounded to nearest on its own
    function automatic logic [63:0] two_pi_fx(input int frac);
        return ((PI_Q60 << 1) + (64'd1 << (59 - frac))) >> (60 - frac);
    endfunction

endpackage
`default_nettype wire

// ===== sv/mpd_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpd_in_if: pose input channel
// Valid/ready channel carrying one six-axis pose word and its valid flag.
// ----------------------------------------------------------------------------
interface mpd_in_if #(
    parameter int COORD_WIDTH = mpd_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] pose_x;
    logic signed [COORD_WIDTH-1:0] pose_y;
    logic signed [COORD_WIDTH-1:0] pose_z;
    logic signed [COORD_WIDTH-1:0] pose_alpha;
    logic signed [COORD_WIDTH-1:0] pose_beta;
    logic signed [COORD_WIDTH-1:0] pose_gamma;
    logic                          pose_valid;

    modport source (
        output valid, pose_x, pose_y, pose_z, pose_alpha, pose_beta, pose_gamma,
               pose_valid,
        input  ready
    );

    modport sink (
        input  valid, pose_x, pose_y, pose_z, pose_alpha, pose_beta, pose_gamma,
               pose_valid,
        output ready
    );
endinterface
`default_nettype wire

// ===== sv/mpd_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpd_out_if: distance output channel
// Valid/ready channel carrying one distance word and the invalid-pose flag.
// ----------------------------------------------------------------------------
interface mpd_out_if;
    logic                  valid;
    logic                  ready;
    mpd_pkg::t_dist        distance;
    logic                  invalid_pose;

    modport source (
        output valid, distance, invalid_pose,
        input  ready
    );

    modport sink (
        input  valid, distance, invalid_pose,
        output ready
    );
endinterface
`default_nettype wire

// ===== sv/mpd_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpd_lane: per-axis error and square
// Absolute difference against the target, optional angle wrap into 0..pi,
// then the masked square. Six register stages, one shared enable.
// ----------------------------------------------------------------------------
module mpd_lane #(
    parameter int COORD_WIDTH = mpd_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = mpd_pkg::FRAC_BITS_DEF,
    parameter bit ANGULAR     = 1'b0
) (
    input  wire                          i_clk,
    input  wire                          i_en,
    input  wire signed [COORD_WIDTH-1:0] i_pose,
    input  wire signed [COORD_WIDTH-1:0] i_target,
    input  wire                          i_axis_on,
    output mpd_pkg::t_sq                 o_sq,
    output logic                         o_over
);
    localparam int CW = COORD_WIDTH;
    localparam int TW = FRAC_BITS + 3;
    localparam int MW = (CW > TW) ? CW : TW;
    localparam int XW = (CW > mpd_pkg::DIST_WIDTH) ? CW : mpd_pkg::DIST_WIDTH;

    // stage 0: absolute difference
    logic signed [CW:0] w_diff;
    logic signed [CW:0] w_abs;
    logic [CW-1:0]      r_d0;

    assign w_diff = $signed({i_pose[CW-1], i_pose}) - $signed({i_target[CW-1], i_target});
    assign w_abs  = w_diff[CW] ? -w_diff : w_diff;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d0 <= w_abs[CW-1:0];
        end
    end

    // stages 1 to 4: angle reduction, or plain delay on a linear axis
    logic [CW-1:0] r_d4;

    if (ANGULAR) begin : g_angle
        localparam logic [63:0] PI_L    = mpd_pkg::pi_fx(FRAC_BITS);
        localparam logic [63:0] TWO_PI  = mpd_pkg::two_pi_fx(FRAC_BITS);
        localparam logic [63:0] RECIP   = (64'd1 << CW) / TWO_PI;
        localparam logic [CW-1:0] RECIP_C = RECIP[CW-1:0];
        localparam logic [TW-1:0] TWO_PI_C = TWO_PI[TW-1:0];
        localparam logic [MW-1:0] TWO_PI_M = TWO_PI[MW-1:0];
        localparam logic [MW-1:0] PI_M     = PI_L[MW-1:0];

        logic [2*CW-1:0]    w_prod;
        logic [CW+TW-1:0]   w_qt;
        logic [CW-1:0]      w_rem;
        logic [MW-1:0]      w_rem_m;
        logic [MW-1:0]      w_m_ext;
        logic signed [MW:0] w_off;
        logic signed [MW:0] w_off_abs;
        logic signed [MW:0] w_fold;
        logic [CW-1:0]      r_d1;
        logic [CW-1:0]      r_q1;
        logic [CW-1:0]      r_d2;
        logic [CW-1:0]      r_qt2;
        logic [CW-1:0]      r_m3;

        // quotient estimate, never above the true quotient and at most one below
        assign w_prod = {{CW{1'b0}}, r_d0} * {{CW{1'b0}}, RECIP_C};
        assign w_qt   = {{TW{1'b0}}, r_q1} * {{CW{1'b0}}, TWO_PI_C};

        // remainder lands in 0..2*two_pi; one subtract corrects it
        assign w_rem   = r_d2 - r_qt2;
        assign w_rem_m = MW'(w_rem);

        // fold into 0..pi
        assign w_m_ext   = MW'(r_m3);
        assign w_off     = $signed({1'b0, w_m_ext}) - $signed({1'b0, PI_M});
        assign w_off_abs = w_off[MW] ? -w_off : w_off;
        assign w_fold    = $signed({1'b0, PI_M}) - w_off_abs;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d1  <= r_d0;
                r_q1  <= w_prod[2*CW-1:CW];
                r_d2  <= r_d1;
                r_qt2 <= w_qt[CW-1:0];
                r_m3  <= (w_rem_m >= TWO_PI_M) ? CW'(w_rem_m - TWO_PI_M) : w_rem;
                r_d4  <= w_fold[CW-1:0];
            end
        end
    end else begin : g_linear
        logic [CW-1:0] r_d1;
        logic [CW-1:0] r_d2;
        logic [CW-1:0] r_d3;

        // match the latency of the angle path
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d1 <= r_d0;
                r_d2 <= r_d1;
                r_d3 <= r_d2;
                r_d4 <= r_d3;
            end
        end
    end

    // stage 5: overflow check and masked square
    logic [XW-1:0]                   w_dx;
    logic                            w_over;
    logic [mpd_pkg::DIST_WIDTH-1:0]  w_d26;

    assign w_dx   = XW'(r_d4);
    assign w_over = w_dx > XW'(mpd_pkg::DIST_MAX);
    assign w_d26  = w_dx[mpd_pkg::DIST_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_over <= i_axis_on && w_over;
            o_sq   <= (i_axis_on && !w_over)
                      ? {{mpd_pkg::DIST_WIDTH{1'b0}}, w_d26} * {{mpd_pkg::DIST_WIDTH{1'b0}}, w_d26}
                      : '0;
        end
    end
endmodule
`default_nettype wire

// ===== sv/mpd_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpd_merge: lane merge
// Registered adder tree over the six squares; ORs the lane overflow flags.
// ----------------------------------------------------------------------------
module mpd_merge (
    input  wire                              i_clk,
    input  wire                              i_en,
    input  wire mpd_pkg::t_sq                i_sq [mpd_pkg::NUM_AXES],
    input  wire [mpd_pkg::NUM_AXES-1:0]      i_over,
    output mpd_pkg::t_sum                    o_sum,
    output logic                             o_over
);
    localparam int PW = mpd_pkg::SQ_WIDTH + 1;
    localparam int NP = mpd_pkg::NUM_AXES / 2;

    logic [PW-1:0] r_pair [NP];
    logic          r_over_a;

    // first level: pairwise sums
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NP; k++) begin
                r_pair[k] <= PW'(i_sq[2*k]) + PW'(i_sq[2*k+1]);
            end
            r_over_a <= |i_over;
        end
    end

    // second level: total
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sum  <= mpd_pkg::SUM_WIDTH'(r_pair[0]) + mpd_pkg::SUM_WIDTH'(r_pair[1])
                      + mpd_pkg::SUM_WIDTH'(r_pair[2]);
            o_over <= r_over_a;
        end
    end
endmodule
`default_nettype wire

// ===== sv/mpd_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpd_sqrt: pipelined integer square root
// One result bit per stage (restoring digit method), floor of the root of a
// 52-bit radicand; flags sums too large for the result width.
// ----------------------------------------------------------------------------
module mpd_sqrt (
    input  wire                  i_clk,
    input  wire                  i_en,
    input  wire mpd_pkg::t_sum   i_sum,
    input  wire                  i_over,
    output mpd_pkg::t_dist       o_root,
    output logic                 o_sat
);
    localparam int NS = mpd_pkg::SQRT_STAGES;
    localparam int VW = mpd_pkg::SQ_WIDTH + 1;

    logic [VW-1:0] r_v   [NS];
    logic [VW-1:0] r_res [NS];
    logic          r_sat [NS];

    for (genvar k = 0; k < NS; k++) begin : g_step
        localparam logic [VW-1:0] STEP_BIT = VW'(1) << (2 * (NS - 1 - k));

        logic [VW-1:0] w_v_in;
        logic [VW-1:0] w_res_in;
        logic          w_sat_in;
        logic [VW-1:0] w_trial;

        if (k == 0) begin : g_first
            assign w_v_in   = VW'(i_sum[mpd_pkg::SQ_WIDTH-1:0]);
            assign w_res_in = '0;
            assign w_sat_in = i_over || (|i_sum[mpd_pkg::SUM_WIDTH-1:mpd_pkg::SQ_WIDTH]);
        end else begin : g_next
            assign w_v_in   = r_v[k-1];
            assign w_res_in = r_res[k-1];
            assign w_sat_in = r_sat[k-1];
        end

        assign w_trial = w_res_in + STEP_BIT;

        // take the bit when the trial fits
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sat[k] <= w_sat_in;
                if (w_v_in >= w_trial) begin
                    r_v[k]   <= w_v_in - w_trial;
                    r_res[k] <= (w_res_in >> 1) + STEP_BIT;
                end else begin
                    r_v[k]   <= w_v_in;
                    r_res[k] <= w_res_in >> 1;
                end
            end
        end
    end

    assign o_root = r_res[NS-1][mpd_pkg::DIST_WIDTH-1:0];
    assign o_sat  = r_sat[NS-1];
endmodule
`default_nettype wire

// ===== sv/masked_pose_distance.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// masked_pose_distance: masked Euclidean pose error with angle wrap
// Scores a six-axis pose against a configured target pose.
// ----------------------------------------------------------------------------
// Usage: the block takes one pose word per clock while the output word is taken
// and returns one distance word per pose, in order (6 lane stages, 2 adder-tree
// stages, 26 square-root stages, one per result bit). All stages advance
// together; when the output word is not taken the pipeline holds and a one-word
// skid register still takes the next pose. Six lanes work side by side, one per
// axis: x, y, z use |pose - target|, the three angles reduce that difference
// modulo two pi and fold it into 0..pi. Axes cleared in axis_mask add nothing.
// A pose flagged not valid returns all ones with invalid_pose set; a root that
// does not fit 26 bits returns all ones with invalid_pose clear. Write the
// target and mask registers only while no pose is in flight.
// ----------------------------------------------------------------------------
module masked_pose_distance #(
    parameter int COORD_WIDTH = mpd_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = mpd_pkg::FRAC_BITS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_wr_en,
    input  wire [mpd_pkg::CFG_IDX_WIDTH-1:0]    i_cfg_idx,
    input  wire [COORD_WIDTH-1:0]               i_cfg_data,
    mpd_in_if.sink                              s_in,
    mpd_out_if.source                           m_out
);
    localparam int NA = mpd_pkg::NUM_AXES;
    localparam int NS = mpd_pkg::NUM_STAGES;

    // configuration registers
    logic signed [COORD_WIDTH-1:0] r_target [NA];
    logic [NA-1:0]                 r_axis_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NA; k++) begin
                r_target[k] <= '0;
            end
            r_axis_mask <= mpd_pkg::AXIS_MASK_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                mpd_pkg::REG_TARGET_X:     r_target[0] <= i_cfg_data;
                mpd_pkg::REG_TARGET_Y:     r_target[1] <= i_cfg_data;
                mpd_pkg::REG_TARGET_Z:     r_target[2] <= i_cfg_data;
                mpd_pkg::REG_TARGET_ALPHA: r_target[3] <= i_cfg_data;
                mpd_pkg::REG_TARGET_BETA:  r_target[4] <= i_cfg_data;
                mpd_pkg::REG_TARGET_GAMMA: r_target[5] <= i_cfg_data;
                mpd_pkg::REG_AXIS_MASK:    r_axis_mask <= i_cfg_data[NA-1:0];
                default: begin
                end
            endcase
        end
    end

    // pipeline advance: hold everything while the output word waits
    logic          w_adv;
    logic [NS-1:0] r_vld;
    logic [NS-1:0] r_bad;

    assign w_adv = !r_vld[NS-1] || m_out.ready;

    // input skid register
    logic                          r_skid_valid;
    logic signed [COORD_WIDTH-1:0] r_skid_pose [NA];
    logic                          r_skid_ok;
    logic signed [COORD_WIDTH-1:0] w_in_pose   [NA];
    logic signed [COORD_WIDTH-1:0] w_src_pose  [NA];
    logic                          w_acc;
    logic                          w_src_valid;
    logic                          w_src_ok;

    assign s_in.ready = !r_skid_valid;
    assign w_acc      = s_in.valid && !r_skid_valid;

    assign w_in_pose[0] = s_in.pose_x;
    assign w_in_pose[1] = s_in.pose_y;
    assign w_in_pose[2] = s_in.pose_z;
    assign w_in_pose[3] = s_in.pose_alpha;
    assign w_in_pose[4] = s_in.pose_beta;
    assign w_in_pose[5] = s_in.pose_gamma;

    always_comb begin
        for (int k = 0; k < NA; k++) begin
            w_src_pose[k] = r_skid_valid ? r_skid_pose[k] : w_in_pose[k];
        end
    end

    assign w_src_valid = r_skid_valid || w_acc;
    assign w_src_ok    = r_skid_valid ? r_skid_ok : s_in.pose_valid;

    // park the word when the pipeline holds, drain it on the next advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (w_adv) begin
            r_skid_valid <= 1'b0;
        end else if (w_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_adv && w_acc) begin
            r_skid_pose <= w_in_pose;
            r_skid_ok   <= s_in.pose_valid;
        end
    end

    // word valid and not-valid-pose flag per stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NS-2:0], w_src_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_bad <= {r_bad[NS-2:0], !w_src_ok};
        end
    end

    // axis lanes
    mpd_pkg::t_sq    w_sq [NA];
    logic [NA-1:0]   w_over;

    for (genvar k = 0; k < NA; k++) begin : g_lane
        mpd_lane #(
            .COORD_WIDTH (COORD_WIDTH),
            .FRAC_BITS   (FRAC_BITS),
            .ANGULAR     (k >= mpd_pkg::NUM_LINEAR)
        ) u_lane (
            .i_clk     (i_clk),
            .i_en      (w_adv),
            .i_pose    (w_src_pose[k]),
            .i_target  (r_target[k]),
            .i_axis_on (r_axis_mask[k]),
            .o_sq      (w_sq[k]),
            .o_over    (w_over[k])
        );
    end

    // merge and root
    mpd_pkg::t_sum  w_sum;
    logic           w_sum_over;
    mpd_pkg::t_dist w_root;
    logic           w_sat;

    mpd_merge u_merge (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_sq   (w_sq),
        .i_over (w_over),
        .o_sum  (w_sum),
        .o_over (w_sum_over)
    );

    mpd_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_sum  (w_sum),
        .i_over (w_sum_over),
        .o_root (w_root),
        .o_sat  (w_sat)
    );

    // output word
    assign m_out.valid        = r_vld[NS-1];
    assign m_out.distance     = (r_bad[NS-1] || w_sat) ? mpd_pkg::DIST_MAX : w_root;
    assign m_out.invalid_pose = r_bad[NS-1];
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for masked_pose_distance
// Drives pose words through the valid/ready input channel, scores each accepted
// pose with an independent fixed-point model of the masked, angle-wrapped
// Euclidean error and compares every distance word in order. Runs directed
// corner poses, then random poses under several target/mask settings and
// several sender/receiver idling patterns.
// ----------------------------------------------------------------------------
module testbench;

    import mpd_pkg::*;

    localparam int COORD_W     = COORD_WIDTH_DEF;
    localparam int FRAC        = FRAC_BITS_DEF;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYC  = NUM_STAGES + 8;

    localparam longint C_MAX = (longint'(1) << (COORD_W - 1)) - 1;
    localparam longint C_MIN = -(longint'(1) << (COORD_W - 1));

    // pi and two pi at FRAC fractional bits, each rounded on its own
    localparam longint PI_FIX = longint'((PI_Q60 + (64'd1 << (59 - FRAC))) >> (60 - FRAC));
    localparam longint TWO_PI_FIX =
        longint'(((PI_Q60 << 1) + (64'd1 << (59 - FRAC))) >> (60 - FRAC));

    localparam longint unsigned DIST_FULL = 64'(DIST_MAX);
    localparam longint unsigned SUM_CEIL  = DIST_FULL * DIST_FULL + 2 * DIST_FULL;

    // index with no register behind it
    localparam logic [CFG_IDX_WIDTH-1:0] REG_UNUSED = 3'd7;

    localparam logic [CFG_IDX_WIDTH-1:0] TARGET_REG [NUM_AXES] = '{
        REG_TARGET_X, REG_TARGET_Y, REG_TARGET_Z,
        REG_TARGET_ALPHA, REG_TARGET_BETA, REG_TARGET_GAMMA
    };

    localparam int SEND_IDLE  [4] = '{0, 64, 0, 19};
    localparam int RECV_STALL [4] = '{0, 0, 64, 19};

    typedef struct packed {
        logic [NUM_AXES-1:0][COORD_W-1:0] coord;
        logic                             ok;
    } t_pose_word;

    typedef struct packed {
        t_dist distance;
        logic  invalid;
    } t_score;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     cfg_wr_en;
    logic [CFG_IDX_WIDTH-1:0] cfg_idx;
    logic [COORD_W-1:0]       cfg_data;

    mpd_in_if #(.COORD_WIDTH(COORD_W)) in_if ();
    mpd_out_if                         out_if ();

    masked_pose_distance #(
        .COORD_WIDTH (COORD_W),
        .FRAC_BITS   (FRAC)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .s_in        (in_if),
        .m_out       (out_if)
    );

    // local copy of the target pose and axis mask
    longint              goal_coord [NUM_AXES];
    logic [NUM_AXES-1:0] axis_on;

    t_pose_word queued_poses [$];
    t_score     pending_scores [$];

    int err_count   = 0;
    int idle_cycles = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        err_count++;
    endtask

    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned root;
        longint unsigned probe;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0) begin
            probe = root + bitv;
            if (v >= probe) begin
                v    = v - probe;
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // masked distance of one pose against the current target
    function automatic t_score score_pose(input t_pose_word p);
        t_score          s;
        longint          diff;
        longint unsigned mag;
        longint unsigned acc;
        bit              sat;
        int              a;
        s.invalid = 1'b0;
        acc = 0;
        sat = 1'b0;
        if (!p.ok) begin
            s.distance = DIST_MAX;
            s.invalid  = 1'b1;
            return s;
        end
        for (a = 0; a < NUM_AXES; a++) begin
            if (axis_on[a]) begin
                diff = longint'($signed(p.coord[a])) - goal_coord[a];
                if (diff < 0)
                    diff = -diff;
                // fold angles: reduce modulo two pi, then mirror into 0..pi
                if (a >= NUM_LINEAR) begin
                    diff = (diff % TWO_PI_FIX) - PI_FIX;
                    if (diff < 0)
                        diff = -diff;
                    diff = PI_FIX - diff;
                    if (diff < 0)
                        diff = -diff;
                end
                mag = longint'(diff);
                if (mag > DIST_FULL)
                    sat = 1'b1;
                else
                    acc += mag * mag;
            end
        end
        if (sat || acc > SUM_CEIL)
            s.distance = DIST_MAX;
        else
            s.distance = t_dist'(floor_root(acc));
        return s;
    endfunction

    function automatic t_pose_word make_pose(input longint x, input longint y,
                                             input longint z, input longint al,
                                             input longint be, input longint ga,
                                             input bit ok);
        t_pose_word p;
        p.coord[0] = COORD_W'(x);
        p.coord[1] = COORD_W'(y);
        p.coord[2] = COORD_W'(z);
        p.coord[3] = COORD_W'(al);
        p.coord[4] = COORD_W'(be);
        p.coord[5] = COORD_W'(ga);
        p.ok       = ok;
        return p;
    endfunction

    // random pose biased toward the target, multiples of pi and the extremes
    function automatic t_pose_word random_pose();
        t_pose_word p;
        longint     v;
        longint     k;
        int         a;
        for (a = 0; a < NUM_AXES; a++) begin
            case ($urandom_range(5))
                0, 1: v = longint'($urandom);
                2: v = goal_coord[a] + longint'($urandom_range(2000)) - 1000;
                3: begin
                    k = longint'($urandom_range(40)) * PI_FIX;
                    if ($urandom_range(1))
                        k = -k;
                    v = goal_coord[a] + k + longint'($urandom_range(4)) - 2;
                end
                4: v = $urandom_range(1) ? C_MAX : C_MIN;
                default: v = longint'($urandom_range(64)) - 32;
            endcase
            p.coord[a] = COORD_W'(v);
        end
        p.ok = ($urandom_range(9) != 0);
        return p;
    endfunction

    // write one register and mirror it into the local copy
    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input longint val);
        logic [COORD_W-1:0] raw;
        raw = COORD_W'(val);
        @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_idx   <= idx;
        cfg_data  <= raw;
        case (idx)
            REG_AXIS_MASK: axis_on = raw[NUM_AXES-1:0];
            REG_UNUSED:    ;
            default:       goal_coord[idx] = longint'($signed(raw));
        endcase
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (queued_poses.size() != 0 || in_if.valid || pending_scores.size() != 0);
    endtask

    // new target pose and mask; a few settings force the mask extremes
    task automatic program_setting(input int k);
        longint v;
        int     a;
        for (a = 0; a < NUM_AXES; a++) begin
            case ($urandom_range(4))
                0:       v = C_MAX;
                1:       v = C_MIN;
                2:       v = 0;
                default: v = longint'($urandom);
            endcase
            write_reg(TARGET_REG[a], v);
        end
        v = longint'($urandom);
        case (k)
            1:       v = v & ~longint'(63);
            4:       v = v | longint'(63);
            default: ;
        endcase
        write_reg(REG_AXIS_MASK, v);
        if (k % 2 == 0)
            write_reg(REG_UNUSED, longint'($urandom));
    endtask

    // drive pose words; score each one as it is taken
    always @(posedge i_clk) begin : drive_poses
        t_pose_word seen;
        t_pose_word next_word;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                seen.coord[0] = in_if.pose_x;
                seen.coord[1] = in_if.pose_y;
                seen.coord[2] = in_if.pose_z;
                seen.coord[3] = in_if.pose_alpha;
                seen.coord[4] = in_if.pose_beta;
                seen.coord[5] = in_if.pose_gamma;
                seen.ok       = in_if.pose_valid;
                pending_scores.push_back(score_pose(seen));
            end
            if (!in_if.valid || in_if.ready) begin
                if (queued_poses.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_word = queued_poses.pop_front();
                    in_if.valid      <= 1'b1;
                    in_if.pose_x     <= next_word.coord[0];
                    in_if.pose_y     <= next_word.coord[1];
                    in_if.pose_z     <= next_word.coord[2];
                    in_if.pose_alpha <= next_word.coord[3];
                    in_if.pose_beta  <= next_word.coord[4];
                    in_if.pose_gamma <= next_word.coord[5];
                    in_if.pose_valid <= next_word.ok;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // take distance words and compare against the oldest pending score
    always @(posedge i_clk) begin : check_scores
        t_score want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (pending_scores.size() == 0) begin
                    report_mismatch($sformatf("distance %0d arrived with no pose pending",
                                              out_if.distance));
                end else begin
                    want = pending_scores.pop_front();
                    if (out_if.distance !== want.distance)
                        report_mismatch($sformatf("distance got %0d want %0d",
                                                  out_if.distance, want.distance));
                    if (out_if.invalid_pose !== want.invalid)
                        report_mismatch($sformatf("invalid_pose got %b want %b",
                                                  out_if.invalid_pose, want.invalid));
                end
            end
            out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // end the run when nothing moves for too long
    always @(posedge i_clk) begin : watchdog
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        int mode;
        int k;
        int a;
        i_rst_n          = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_idx          = '0;
        cfg_data         = '0;
        in_if.valid      = 1'b0;
        in_if.pose_x     = '0;
        in_if.pose_y     = '0;
        in_if.pose_z     = '0;
        in_if.pose_alpha = '0;
        in_if.pose_beta  = '0;
        in_if.pose_gamma = '0;
        in_if.pose_valid = 1'b0;
        out_if.ready     = 1'b0;
        for (a = 0; a < NUM_AXES; a++)
            goal_coord[a] = 0;
        axis_on = AXIS_MASK_RESET;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset target: field extremes, invalid poses, angle wrap points
        queued_poses.push_back(make_pose(0, 0, 0, 0, 0, 0, 1));
        queued_poses.push_back(make_pose(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 1));
        queued_poses.push_back(make_pose(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 1));
        queued_poses.push_back(make_pose(C_MAX, 0, 0, 0, 0, 0, 1));
        queued_poses.push_back(make_pose(0, 0, 0, PI_FIX, PI_FIX + 1, PI_FIX - 1, 1));
        queued_poses.push_back(make_pose(0, 0, 0, TWO_PI_FIX, TWO_PI_FIX - 1,
                                         TWO_PI_FIX + 1, 1));
        queued_poses.push_back(make_pose(0, 0, 0, -PI_FIX, -TWO_PI_FIX,
                                         -3 * TWO_PI_FIX - 7, 1));
        queued_poses.push_back(make_pose(0, 0, 0, C_MIN, C_MAX, 5 * TWO_PI_FIX + PI_FIX, 1));
        queued_poses.push_back(make_pose(0, 0, 0, 0, 0, 0, 0));
        queued_poses.push_back(make_pose(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 0));
        queued_poses.push_back(make_pose(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 0));
        wait_drained();

        // extreme targets; the unused index must not disturb the mask
        write_reg(REG_TARGET_X, C_MAX);
        write_reg(REG_TARGET_Y, C_MIN);
        write_reg(REG_TARGET_Z, C_MAX);
        write_reg(REG_TARGET_ALPHA, C_MIN);
        write_reg(REG_TARGET_BETA, C_MAX);
        write_reg(REG_TARGET_GAMMA, C_MIN);
        write_reg(REG_AXIS_MASK, 63);
        write_reg(REG_UNUSED, 0);
        queued_poses.push_back(make_pose(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, 1));
        queued_poses.push_back(make_pose(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, 1));
        queued_poses.push_back(make_pose(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, 0));
        wait_drained();

        // empty mask, upper data bits set
        write_reg(REG_AXIS_MASK, longint'(24'hFFFFC0));
        queued_poses.push_back(make_pose(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, 1));
        queued_poses.push_back(make_pose(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, 0));
        wait_drained();

        // angles only, then linear only
        write_reg(REG_AXIS_MASK, 6'b111000);
        queued_poses.push_back(make_pose(0, 0, 0, PI_FIX, 3 * PI_FIX, -PI_FIX, 1));
        wait_drained();
        write_reg(REG_AXIS_MASK, 6'b000111);
        queued_poses.push_back(make_pose(C_MIN, 0, 12345, PI_FIX, 3 * PI_FIX, -PI_FIX, 1));
        wait_drained();

        // random poses; hold the sender mid-setting until all scores are back
        for (mode = 0; mode < 4; mode++) begin
            send_idle_pct  = SEND_IDLE[mode];
            recv_stall_pct = RECV_STALL[mode];
            for (k = 0; k < 2; k++) begin
                program_setting(mode * 2 + k);
                repeat (2) begin
                    repeat (88) queued_poses.push_back(random_pose());
                    wait_drained();
                end
            end
        end

        repeat (SETTLE_CYC) @(posedge i_clk);
        if (pending_scores.size() != 0)
            report_mismatch($sformatf("%0d scores never arrived", pending_scores.size()));
        if (err_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
